// ----- hdl/fic_pkg.sv -----
// ----------------------------------------------------------------------------
// fic_pkg: shared constants and types
// Widths, limits and the structs that run between the walker and the top
// level of the inversion counter.
// ----------------------------------------------------------------------------
package fic_pkg;

  // tree positions run 1..MAX_SIZE, stored at address position-1
  localparam int MAX_SIZE = 1024;
  localparam int AW       = $clog2(MAX_SIZE);
  localparam int PW       = $clog2(MAX_SIZE + 1);

  // item and register field widths
  localparam int VW = 11;
  localparam int TW = 19;
  localparam int CW = 11;

  // common width for size and value compares
  localparam int NW = (PW > VW) ? PW : VW;

  // one query walk sums at most PW counters
  localparam int SUMW = CW + PW;
  localparam int TSW  = ((TW > SUMW) ? TW : SUMW) + 1;

  localparam logic [CW-1:0] CELL_MAX   = {CW{1'b1}};
  localparam logic [TW-1:0] TOTAL_MAX  = {TW{1'b1}};
  localparam logic [VW-1:0] SIZE_RESET = VW'(1024);

  // one tree memory access request
  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [CW-1:0] wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

  // one result item
  typedef struct packed {
    logic [TW-1:0] inversions;
    logic          done_res;
  } result_t;

endpackage

// ----- hdl/fic_if.sv -----
// ----------------------------------------------------------------------------
// fic_in_if / fic_out_if: item channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface fic_in_if;
  import fic_pkg::*;

  logic          valid;
  logic          ready;
  logic [VW-1:0] value;
  logic          last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface fic_out_if;
  import fic_pkg::*;

  logic          valid;
  logic          ready;
  logic [TW-1:0] inversions;
  logic          done_res;

  modport source (output valid, output inversions, output done_res, input ready);
  modport sink   (input valid, input inversions, input done_res, output ready);
endinterface

// ----- hdl/fenwick_inversion_counter.sv -----
// ----------------------------------------------------------------------------
// fenwick_inversion_counter: streaming permutation inversion counter
// Counts inversions with a binary indexed tree held in one two-port RAM.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+------------------------------
//   in_item  | in  | valid/ready          | value[10:0], last
//   out_item | out | valid/ready          | inversions[18:0], done_res
//   cfg      | in  | cfg_we, no back-pressure | cfg_wdata[10:0] = size_in_use
//
// An item runs a query walk and then an update walk over the tree; a value
// out of range skips both walks. The query and update walks each read the
// tree RAM once a cycle.
// After reset, and after each item marked last, a clearing pass writes zero to
// all MAX_SIZE entries while in_item.ready stays low.
// A result waits in the output register; the walker takes the next item while
// it waits and stalls only when a second result is ready before the first left.
// ----------------------------------------------------------------------------
module fenwick_inversion_counter (
  input  logic                   clk,
  input  logic                   rst_n,
  fic_in_if.sink                 in_item,
  fic_out_if.source              out_item,
  input  logic                   cfg_we,
  input  logic [fic_pkg::VW-1:0] cfg_wdata
);
  import fic_pkg::*;

  logic [VW-1:0] size_r;
  logic          out_valid_r;
  result_t       out_data_r;

  mem_req_t      mem_req;
  logic [CW-1:0] mem_rdata;
  logic          res_valid;
  result_t       res;
  logic          res_ready;

  // size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  fic_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_SIZE)
  ) u_tree (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  fic_walk u_walk (
    .clk         (clk),
    .rst_n       (rst_n),
    .size_in_use (size_r),
    .in_valid    (in_item.valid),
    .in_value    (in_item.value),
    .in_last     (in_item.last),
    .in_ready    (in_item.ready),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready)
  );

  // output register
  assign res_ready = !out_valid_r || out_item.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_item.valid      = out_valid_r;
  assign out_item.inversions = out_data_r.inversions;
  assign out_item.done_res   = out_data_r.done_res;

`ifndef SYNTHESIS
  // an update write never lands on the entry read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we && mem_req.wdata != '0) |-> (mem_req.raddr != mem_req.waddr))
    else $error("tree read and update write hit the same entry");

  // one item at a time: ready drops right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_item.valid && in_item.ready) |=> !in_item.ready)
    else $error("input accepted while an item is in the walk");

  // a closing result starts the clearing pass
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_item.valid) && out_item.done_res) |-> !in_item.ready)
    else $error("input open while tree should be clearing");
`endif

endmodule

// ----- hdl/fic_ram.sv -----
// ----------------------------------------------------------------------------
// fic_ram: generic two-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/fic_walk.sv -----
// ----------------------------------------------------------------------------
// fic_walk: tree walker
// Query walk, update walk and clearing pass over the count tree, plus the
// running inversion total.
// ----------------------------------------------------------------------------
module fic_walk (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [fic_pkg::VW-1:0] size_in_use,
  input  logic                   in_valid,
  input  logic [fic_pkg::VW-1:0] in_value,
  input  logic                   in_last,
  output logic                   in_ready,
  output fic_pkg::mem_req_t      mem_req,
  input  logic [fic_pkg::CW-1:0] mem_rdata,
  output logic                   res_valid,
  output fic_pkg::result_t       res,
  input  logic                   res_ready
);
  import fic_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QSTART,
    ST_QWALK,
    ST_UWALK,
    ST_DONE
  } state_t;

  state_t          state_r;
  logic [PW-1:0]   idx_r;
  logic [PW-1:0]   pos_r;
  logic [PW-1:0]   n_r;
  logic [SUMW-1:0] sum_r;
  logic [TW-1:0]   total_r;
  logic            last_r;
  logic [AW-1:0]   clr_r;

  logic [NW-1:0]  size_ext;
  logic [NW-1:0]  eff_n;
  logic [NW-1:0]  val_ext;
  logic           val_ok;
  logic [NW-1:0]  pos_full;
  logic [PW-1:0]  idx_dec;
  logic [PW-1:0]  q_nxt;
  logic [PW-1:0]  q_dec;
  logic [PW-1:0]  pos_dec;
  logic [PW-1:0]  u_low;
  logic [PW:0]    u_nxt;
  logic [PW:0]    u_dec;
  logic           u_more;
  logic [CW-1:0]  cell_inc;
  logic [TSW-1:0] tot_sum;
  logic [TW-1:0]  tot_sat;

  // effective size and tree position of the incoming value
  always_comb begin
    size_ext = NW'(size_in_use);
    val_ext  = NW'(in_value);
    if (size_ext == '0) begin
      eff_n = NW'(1);
    end else if (size_ext > NW'(MAX_SIZE)) begin
      eff_n = NW'(MAX_SIZE);
    end else begin
      eff_n = size_ext;
    end
    val_ok   = (val_ext != '0) && (val_ext <= eff_n);
    pos_full = eff_n - val_ext + NW'(1);
  end

  // index arithmetic for both walks
  always_comb begin
    idx_dec  = idx_r - PW'(1);
    q_nxt    = idx_r & idx_dec;
    q_dec    = q_nxt - PW'(1);
    pos_dec  = pos_r - PW'(1);
    u_low    = idx_r & (~idx_r + PW'(1));
    u_nxt    = {1'b0, idx_r} + {1'b0, u_low};
    u_dec    = u_nxt - (PW+1)'(1);
    u_more   = u_nxt <= {1'b0, n_r};
    cell_inc = (mem_rdata == CELL_MAX) ? mem_rdata : mem_rdata + CW'(1);
  end

  // saturating running total
  always_comb begin
    tot_sum = TSW'(total_r) + TSW'(sum_r);
    tot_sat = (tot_sum > TSW'(TOTAL_MAX)) ? TOTAL_MAX : tot_sum[TW-1:0];
  end

  // memory requests follow the state; read addresses go out ahead of use, since the RAM registers its read data
  always_comb begin
    mem_req = '{we: 1'b0, waddr: '0, wdata: '0, raddr: idx_dec[AW-1:0]};
    unique case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
      end
      ST_QWALK: begin
        mem_req.raddr = (q_nxt != '0) ? q_dec[AW-1:0] : pos_dec[AW-1:0];
      end
      ST_UWALK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_dec[AW-1:0];
        mem_req.wdata = cell_inc;
        // a step past the top of the tree would wrap onto the write; read entry zero
        mem_req.raddr = u_nxt[PW] ? '0 : u_dec[AW-1:0];
      end
      default: ;
    endcase
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign res_valid      = (state_r == ST_DONE);
  assign res.inversions = tot_sat;
  assign res.done_res   = last_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      total_r <= '0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(MAX_SIZE - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            n_r     <= PW'(eff_n);
            pos_r   <= PW'(pos_full);
            idx_r   <= PW'(pos_full);
            last_r  <= in_last;
            sum_r   <= '0;
            state_r <= val_ok ? ST_QSTART : ST_DONE;
          end
        end
        ST_QSTART: begin
          state_r <= ST_QWALK;
        end
        ST_QWALK: begin
          sum_r <= sum_r + SUMW'(mem_rdata);
          if (q_nxt != '0) begin
            idx_r <= q_nxt;
          end else begin
            idx_r   <= pos_r;
            state_r <= ST_UWALK;
          end
        end
        ST_UWALK: begin
          if (u_more) begin
            idx_r <= u_nxt[PW-1:0];
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            if (last_r) begin
              total_r <= '0;
              clr_r   <= '0;
              state_r <= ST_CLEAR;
            end else begin
              total_r <= tot_sat;
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_CLEAR;
      endcase
    end
  end

endmodule

// ----- tb/sv/fenwick_inversion_counter_tb.sv -----
// ----------------------------------------------------------------------------
// fenwick_inversion_counter_tb: self-checking testbench for the counter
// Drives permutations and broken or noisy value streams through the item
// channel, rewrites the size register between phases, and checks every
// result item against a behavioral tree model kept inside the bench or a listed total.
// ----------------------------------------------------------------------------
module fenwick_inversion_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fic_pkg::*;

  // run control
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned END_SETTLE     = 64;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned PHASE_ITEMS    = 70;
  localparam int unsigned REPEAT_ITEMS   = 300;
  localparam int unsigned MAX_REPORTS    = 200;

  // idle pattern per phase: none, sender, receiver, both
  localparam int unsigned SEND_IDLE_PCT [4] = '{0, 84, 0, 34};
  localparam int unsigned RECV_STALL_PCT[4] = '{0, 0, 84, 34};

  // size register per random phase; 2047 acts as the full tree
  localparam logic [VW-1:0] PHASE_SIZES [8] = '{
    11'd16, 11'd1, 11'd1024, 11'd9, 11'd2047, 11'd64, 11'd3, 11'd500
  };

  typedef enum logic {ROW_SIZE, ROW_ITEM} row_kind_t;

  // directed row: a size write, or an item with an optional known total
  typedef struct packed {
    row_kind_t     kind;
    logic [VW-1:0] value;
    logic          last;
    logic          known;
    logic [TW-1:0] total;
  } stim_row_t;

  typedef struct packed {
    logic    known;
    result_t res;
  } listed_total_t;

  localparam stim_row_t DIRECTED_ROWS [27] = '{
    // after reset: full size, out-of-range values, repeats
    '{ROW_ITEM, 11'd1024, 1'b0, 1'b1, 19'd0},
    '{ROW_ITEM, 11'd1,    1'b0, 1'b1, 19'd1},
    '{ROW_ITEM, 11'd0,    1'b0, 1'b1, 19'd1},
    '{ROW_ITEM, 11'd2047, 1'b0, 1'b1, 19'd1},
    '{ROW_ITEM, 11'd1,    1'b0, 1'b0, 19'd0},
    '{ROW_ITEM, 11'd512,  1'b1, 1'b0, 19'd0},
    '{ROW_ITEM, 11'd1,    1'b1, 1'b1, 19'd0},
    // size zero behaves as one
    '{ROW_SIZE, 11'd0,    1'b0, 1'b0, 19'd0},
    '{ROW_ITEM, 11'd1,    1'b0, 1'b1, 19'd0},
    '{ROW_ITEM, 11'd1,    1'b0, 1'b0, 19'd0},
    '{ROW_ITEM, 11'd2,    1'b0, 1'b1, 19'd1},
    // oversize register, changed in the middle of a sequence
    '{ROW_SIZE, 11'd2047, 1'b0, 1'b0, 19'd0},
    '{ROW_ITEM, 11'd1024, 1'b0, 1'b0, 19'd0},
    '{ROW_ITEM, 11'd1,    1'b1, 1'b0, 19'd0},
    // descending then ascending permutation of four
    '{ROW_SIZE, 11'd4,    1'b0, 1'b0, 19'd0},
    '{ROW_ITEM, 11'd4,    1'b0, 1'b1, 19'd0},
    '{ROW_ITEM, 11'd3,    1'b0, 1'b1, 19'd1},
    '{ROW_ITEM, 11'd2,    1'b0, 1'b1, 19'd3},
    '{ROW_ITEM, 11'd1,    1'b1, 1'b1, 19'd6},
    '{ROW_ITEM, 11'd1,    1'b0, 1'b1, 19'd0},
    '{ROW_ITEM, 11'd2,    1'b0, 1'b1, 19'd0},
    '{ROW_ITEM, 11'd3,    1'b0, 1'b1, 19'd0},
    '{ROW_ITEM, 11'd4,    1'b1, 1'b1, 19'd0},
    // top of the value range
    '{ROW_SIZE, 11'd1024, 1'b0, 1'b0, 19'd0},
    '{ROW_ITEM, 11'd1024, 1'b0, 1'b1, 19'd0},
    '{ROW_ITEM, 11'd1023, 1'b0, 1'b0, 19'd0},
    '{ROW_ITEM, 11'd1024, 1'b1, 1'b0, 19'd0}
  };

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic [VW-1:0] cfg_wdata;

  fic_in_if  in_ch ();
  fic_out_if out_ch ();

  fenwick_inversion_counter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // shadow of the block state
  logic [CW-1:0] shadow_counts [1:MAX_SIZE];
  logic [TW-1:0] shadow_total;
  logic [VW-1:0] shadow_size;

  result_t       pending_totals [$];
  listed_total_t listed_totals  [$];

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned quiet_cycles;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_shadow();
    for (int i = 1; i <= MAX_SIZE; i++) shadow_counts[i] = '0;
    shadow_total = '0;
  endfunction

  // running inversion total after one value: prefix query, then tree update
  function automatic result_t next_inversion_total(input logic [VW-1:0] v, input logic l);
    result_t     res;
    int unsigned n;
    int unsigned pos;
    int unsigned i;
    int unsigned acc;
    n = shadow_size;
    if (n == 0) n = 1;
    if (n > MAX_SIZE) n = MAX_SIZE;
    if (v >= 1 && v <= n) begin
      pos = n - v + 1;
      acc = shadow_total;
      i = pos;
      while (i != 0) begin
        acc += shadow_counts[i];
        i = i & (i - 1);
      end
      if (acc > TOTAL_MAX) acc = TOTAL_MAX;
      shadow_total = TW'(acc);
      i = pos;
      while (i != 0 && i <= n) begin
        if (shadow_counts[i] != CELL_MAX) shadow_counts[i] = shadow_counts[i] + 1'b1;
        i += i & (~i + 1);
      end
    end
    res.inversions = shadow_total;
    res.done_res   = l;
    if (l) clear_shadow();
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
  endtask

  // receiver: random back-pressure
  always @(posedge clk) out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

  // predict on input accept, compare on output accept
  always @(posedge clk) begin : track_items
    result_t       want;
    listed_total_t tag;
    if (rst_n) begin
      if (cfg_we) shadow_size = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        want = next_inversion_total(in_ch.value, in_ch.last);
        if (listed_totals.size() != 0) begin
          tag = listed_totals.pop_front();
          if (tag.known) want = tag.res;
        end
        pending_totals = {pending_totals, want};
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_totals.size() == 0) begin
          report_mismatch("result with nothing pending", out_ch.inversions, 0);
        end else begin
          want = pending_totals.pop_front();
          if (out_ch.inversions != want.inversions)
            report_mismatch("inversions", out_ch.inversions, want.inversions);
          if (out_ch.done_res != want.done_res)
            report_mismatch("done_res", out_ch.done_res, want.done_res);
        end
      end
    end
  end

  // watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst_n && !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready))
      quiet_cycles++;
    else
      quiet_cycles = 0;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one item, with an optional random gap in front
  task automatic send_item(input logic [VW-1:0] v, input logic l, input logic known,
                           input logic [TW-1:0] total);
    listed_total_t tag;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    tag.known          = known;
    tag.res.inversions = total;
    tag.res.done_res   = l;
    listed_totals = {listed_totals, tag};
    in_ch.value <= v;
    in_ch.last  <= l;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop sending and wait for every pending result, plus a margin
  task automatic drain_results(input int unsigned margin);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_totals.size() != 0) @(posedge clk);
    repeat (margin) @(posedge clk);
  endtask

  task automatic write_size(input logic [VW-1:0] size);
    drain_results(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one random sequence: permutation (random values above size 24), descending run, open fragment or noise
  task automatic send_sequence(input int unsigned n, inout int unsigned sent);
    logic [VW-1:0] vals [$];
    logic [VW-1:0] t;
    int unsigned   roll;
    int unsigned   len;
    int unsigned   k;
    logic          closed;
    logic          noise;
    logic          l;
    roll   = $urandom_range(0, 99);
    closed = 1'b0;
    noise  = 1'b0;
    if (roll < 70) begin
      closed = 1'b1;
      if (n <= 24) begin
        for (int j = 1; j <= n; j++) vals = {vals, VW'(j)};
        for (int j = n - 1; j > 0; j--) begin
          k = $urandom_range(0, j);
          t = vals[j];
          vals[j] = vals[k];
          vals[k] = t;
        end
      end else begin
        len = $urandom_range(4, 24);
        repeat (len) vals = {vals, VW'($urandom_range(1, n))};
      end
      if (roll >= 60) vals.rsort();
    end else if (roll < 85) begin
      // fragment left open, runs into the next sequence
      len = $urandom_range(1, 8);
      repeat (len) vals = {vals, VW'($urandom_range(1, n))};
    end else begin
      noise = 1'b1;
      len = $urandom_range(1, 6);
      repeat (len) vals = {vals, VW'($urandom_range(0, 2047))};
    end
    for (int j = 0; j < vals.size(); j++) begin
      if (noise) l = ($urandom_range(0, 3) == 0);
      else       l = closed && (j == vals.size() - 1);
      send_item(vals[j], l, 1'b0, '0);
      sent++;
    end
  endtask

  // main sequence
  initial begin : stimulus
    int unsigned sent;
    int unsigned n;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    in_ch.last    = 1'b0;
    out_ch.ready  = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    mismatches    = 0;
    results_seen  = 0;
    quiet_cycles  = 0;
    shadow_size   = SIZE_RESET;
    clear_shadow();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int r = 0; r < $size(DIRECTED_ROWS); r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_SIZE)
        write_size(DIRECTED_ROWS[r].value);
      else
        send_item(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].last,
                  DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].total);
    end

    // one long run of repeats at size one, pushing the counter and total high
    write_size(11'd1);
    for (int j = 0; j < REPEAT_ITEMS; j++) begin
      if (j == REPEAT_ITEMS - 1) send_item(11'd0, 1'b1, 1'b0, '0);
      else                       send_item(11'd1, 1'b0, 1'b0, '0);
    end

    // random phases, each with its own size and idle pattern
    for (int ph = 0; ph < $size(PHASE_SIZES); ph++) begin
      write_size(PHASE_SIZES[ph]);
      send_idle_pct = SEND_IDLE_PCT[ph % 4];
      stall_pct     = RECV_STALL_PCT[ph % 4];
      n = PHASE_SIZES[ph];
      if (n == 0) n = 1;
      if (n > MAX_SIZE) n = MAX_SIZE;
      sent = 0;
      while (sent < PHASE_ITEMS) send_sequence(n, sent);
    end

    drain_results(END_SETTLE);
    if (mismatches == 0 && pending_totals.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
